FILE: sv/all_zero_window_search_defines.svh
// Assertion macros shared by the all-zero window search checker.
`ifndef ALL_ZERO_WINDOW_SEARCH_DEFINES_SVH
`define ALL_ZERO_WINDOW_SEARCH_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define AZWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define AZWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches reset itself.
`define AZWS_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/azws_pkg.sv
// Shared constants and types of the all-zero window search.
package azws_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int RUN_W     = 7;
    localparam int POS_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS = 3'd3;

    localparam logic [CFG_W-1:0] NUM_ROWS_RST = 7'd8;
    localparam logic [CFG_W-1:0] NUM_COLS_RST = 7'd8;
    localparam logic [CFG_W-1:0] WIN_ROWS_RST = 7'd2;
    localparam logic [CFG_W-1:0] WIN_COLS_RST = 7'd2;

    // Broadcast to every cell of the column-run chain.
    typedef struct packed {
        logic             shift;
        logic [RUN_W-1:0] run;
    } t_cell_ctl;

endpackage

FILE: sv/azws_cell.sv
// One stage of the column zero-run delay chain.
module azws_cell #(
    parameter int IDX   = 0,
    parameter int PTR_W = 1
) (
    input  logic                      i_clk,
    input  azws_pkg::t_cell_ctl       i_ctl,
    input  logic [PTR_W-1:0]          i_ins_pt,
    input  logic [azws_pkg::RUN_W-1:0] i_left,
    output logic [azws_pkg::RUN_W-1:0] o_run
);

    logic [azws_pkg::RUN_W-1:0] r_run;

    // Take the fresh count at the insertion point, else advance from the left.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_run <= (i_ins_pt == PTR_W'(IDX)) ? i_ctl.run : i_left;
        end
    end

    assign o_run = r_run;

endmodule

FILE: sv/all_zero_window_search.sv
// Top level of the all-zero window search over a raster-order binary matrix.
//
// Input channel: one matrix cell per request on i_cell_req, raster order,
// with i_in_valid / o_in_ready. Output channel: one result per input request
// (o_match, o_top_row, o_left_col, o_frame_end) with o_out_valid /
// i_out_ready. A result reports whether the window ending at that cell is all
// zeros, and if so its top-left corner; o_frame_end marks the matrix's last cell.
//
// Throughput is one request per cycle unless the receiver stalls, and each
// result goes straight into the output register. The per-column zero counts
// live in a chain of MAX_COLS cells: each accepted request enters its count at
// cell MAX_COLS - num_cols and the chain advances, so the last cell always
// holds the same column of the row above.
//
// While the receiver stalls, the held result stays put and o_in_ready drops
// only if the output register is still full. Reset (synchronous, active low)
// restores the default sizes (8 x 8 matrix, 2 x 2 window), restarts the frame
// and empties the output register; the chain needs no clearing, since row 0
// always rewrites it before use. A known-index write also restarts the frame.
module all_zero_window_search #(
    parameter int MAX_COLS = azws_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = azws_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [azws_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [azws_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cell_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_match,
    output logic [azws_pkg::POS_W-1:0]     o_top_row,
    output logic [azws_pkg::POS_W-1:0]     o_left_col,
    output logic                           o_frame_end
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int BW  = (RW > CLW) ? RW : CLW;
    localparam int CW  = ((BW > azws_pkg::CFG_W) ? BW : azws_pkg::CFG_W) + 1;
    localparam int RUN_W = azws_pkg::RUN_W;
    localparam int POS_W = azws_pkg::POS_W;

    // Configuration registers
    logic [azws_pkg::CFG_W-1:0] r_num_rows, r_num_cols, r_win_rows, r_win_cols;

    // Frame position and horizontal run
    logic [RW-1:0]    r_row;
    logic [CLW-1:0]   r_col;
    logic [RUN_W-1:0] r_qrun;

    // Output register
    logic             r_out_valid, r_match, r_frame_end;
    logic [POS_W-1:0] r_top_row, r_left_col;

    logic [azws_pkg::CFG_W-1:0] w_rows, w_cols, w_wr, w_wc;
    logic [CLW-1:0]   w_ins_pt;
    logic [CW-1:0]    w_row_ext, w_col_ext, w_rows_ext, w_cols_ext;
    logic [CW-1:0]    w_row_inc, w_col_inc;
    logic [RUN_W-1:0] w_tail, w_run_prev, n_run, w_hrun_prev, n_qrun;
    logic             w_accept, w_cfg_hit, w_qual, n_match, n_frame_end;
    logic [POS_W-1:0] n_top_row, n_left_col;
    logic [RW-1:0]    n_row;
    logic [CLW-1:0]   n_col;
    azws_pkg::t_cell_ctl w_ctl;
    logic [RUN_W-1:0] w_chain [MAX_COLS];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Size clamping: zero acts as one, matrix sizes cap at the maximum.
    always_comb begin
        w_rows = r_num_rows;
        if (r_num_rows == '0) begin
            w_rows = 7'd1;
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            w_rows = 7'(MAX_ROWS);
        end
        w_cols = r_num_cols;
        if (r_num_cols == '0) begin
            w_cols = 7'd1;
        end else if (32'(r_num_cols) > MAX_COLS) begin
            w_cols = 7'(MAX_COLS);
        end
        w_wr = (r_win_rows == '0) ? 7'd1 : r_win_rows;
        w_wc = (r_win_cols == '0) ? 7'd1 : r_win_cols;
    end

    assign w_ins_pt = CLW'(MAX_COLS - int'(w_cols));

    assign w_row_ext  = CW'(r_row);
    assign w_col_ext  = CW'(r_col);
    assign w_rows_ext = CW'(w_rows);
    assign w_cols_ext = CW'(w_cols);
    assign w_row_inc  = w_row_ext + CW'(1);
    assign w_col_inc  = w_col_ext + CW'(1);

    assign w_tail = w_chain[MAX_COLS-1];

    // Vertical run, horizontal run and the match decision for this cell.
    always_comb begin
        w_run_prev = (r_row == '0) ? '0 : w_tail;
        if (i_cell_req) begin
            n_run = '0;
        end else if (w_run_prev < w_wr) begin
            n_run = w_run_prev + RUN_W'(1);
        end else begin
            n_run = w_run_prev;
        end

        w_qual      = (n_run >= w_wr);
        w_hrun_prev = (r_col == '0) ? '0 : r_qrun;
        if (!w_qual) begin
            n_qrun = '0;
        end else if (w_hrun_prev < w_wc) begin
            n_qrun = w_hrun_prev + RUN_W'(1);
        end else begin
            n_qrun = w_hrun_prev;
        end

        n_match     = w_qual && (n_qrun >= w_wc);
        n_top_row   = n_match ? POS_W'(w_row_inc[POS_W-1:0] - w_wr[POS_W-1:0]) : '0;
        n_left_col  = n_match ? POS_W'(w_col_inc[POS_W-1:0] - w_wc[POS_W-1:0]) : '0;
        n_frame_end = (w_row_inc == w_rows_ext) && (w_col_inc == w_cols_ext);

        // Advance the raster position, wrapping at the matrix edges.
        n_col = r_col;
        n_row = r_row;
        if (w_col_inc >= w_cols_ext) begin
            n_col = '0;
            n_row = (w_row_inc >= w_rows_ext) ? '0 : RW'(w_row_inc);
        end else begin
            n_col = CLW'(w_col_inc);
        end
    end

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == azws_pkg::REG_NUM_ROWS ||
                                    i_cfg_idx == azws_pkg::REG_NUM_COLS ||
                                    i_cfg_idx == azws_pkg::REG_WIN_ROWS ||
                                    i_cfg_idx == azws_pkg::REG_WIN_COLS);

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= azws_pkg::NUM_ROWS_RST;
            r_num_cols <= azws_pkg::NUM_COLS_RST;
            r_win_rows <= azws_pkg::WIN_ROWS_RST;
            r_win_cols <= azws_pkg::WIN_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                azws_pkg::REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                azws_pkg::REG_NUM_COLS: r_num_cols <= i_cfg_data;
                azws_pkg::REG_WIN_ROWS: r_win_rows <= i_cfg_data;
                azws_pkg::REG_WIN_COLS: r_win_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame position; a register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_qrun <= '0;
        end else if (w_cfg_hit) begin
            r_row  <= '0;
            r_col  <= '0;
            r_qrun <= '0;
        end else if (w_accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_qrun <= n_qrun;
        end
    end

    // Output register: load on accept, empty once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_match     <= n_match;
            r_top_row   <= n_top_row;
            r_left_col  <= n_left_col;
            r_frame_end <= n_frame_end;
        end
    end

    // Column run chain
    assign w_ctl.shift = w_accept;
    assign w_ctl.run   = n_run;

    for (genvar g = 0; g < MAX_COLS; g++) begin : g_cell
        logic [RUN_W-1:0] w_left;
        if (g == 0) begin : g_head
            assign w_left = n_run;
        end else begin : g_body
            assign w_left = w_chain[g-1];
        end
        azws_cell #(
            .IDX   (g),
            .PTR_W (CLW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_ins_pt (w_ins_pt),
            .i_left   (w_left),
            .o_run    (w_chain[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_match     = r_match;
    assign o_top_row   = r_top_row;
    assign o_left_col  = r_left_col;
    assign o_frame_end = r_frame_end;

endmodule

FILE: sv/azws_checker.sv
// Port-level checker for the all-zero window search, bound to the top level.
`include "all_zero_window_search_defines.svh"

module azws_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_match,
    input logic [azws_pkg::POS_W-1:0]     o_top_row,
    input logic [azws_pkg::POS_W-1:0]     o_left_col
);

    `AZWS_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid, "output valid after reset")
    `AZWS_ASSERT_NXT(a_acc_result, i_in_valid && o_in_ready, o_out_valid, "request gave no result")
    `AZWS_ASSERT_IMP(a_nomatch_zero, o_out_valid && !o_match, o_top_row == '0 && o_left_col == '0, "corner set without match")
    `AZWS_ASSERT_NXT(a_hold_valid, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

endmodule

bind all_zero_window_search azws_checker u_azws_checker (.*);
